// ===== src/joystick_radial_clamp_defines.svh =====
// ----------------------------------------------------------------------------
// joystick radial clamp assertion macros
// wraps concurrent assertions so synthesis sees nothing of them
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_RADIAL_CLAMP_DEFINES_SVH
`define JOYSTICK_RADIAL_CLAMP_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every edge out of reset
`define JRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define JRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define JRC_ASSERT(label, prop, msg)
`define JRC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== src/jrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrc_pkg
// shared types and constants of the joystick radial clamp pipeline
// ----------------------------------------------------------------------------
package jrc_pkg;

	localparam int RawW  = 10;
	localparam int AxisW = 7;
	localparam int FracW = 7;
	localparam int ProdW = 2 * AxisW;
	localparam int SumW  = ProdW + 1;
	localparam int Iters = 6;

	localparam logic [AxisW-1:0] AxisMax  = 7'd127;
	localparam logic [AxisW-1:0] FactorLo = 7'd64;
	localparam logic [AxisW-1:0] FactorHi = 7'd127;
	localparam logic [ProdW-1:0] RadiusSq = 14'd16129;

	typedef struct packed {
		logic [RawW-1:0] x_raw;
		logic [RawW-1:0] y_raw;
	} jrc_in_t;

	typedef struct packed {
		logic [RawW-1:0] x_out;
		logic [RawW-1:0] y_out;
		logic            was_scaled;
	} jrc_out_t;

	// state of one item as it moves down the search pipeline
	typedef struct packed {
		logic [RawW-1:0]  x_raw;
		logic [RawW-1:0]  y_raw;
		logic [AxisW-1:0] a;
		logic [AxisW-1:0] b;
		logic [AxisW-1:0] lo;
		logic [AxisW-1:0] hi;
		logic [AxisW-1:0] mid;
		logic [AxisW-1:0] sa;
		logic [AxisW-1:0] sb;
		logic             outside;
	} jrc_work_t;

endpackage

// ===== src/jrc_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrc_prep
// quarter-scale clamp of both axes and the outside-circle test
// ----------------------------------------------------------------------------
module jrc_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  jrc_pkg::jrc_in_t  in_data,
	output logic              out_valid,
	output jrc_pkg::jrc_work_t out_work
);

	logic [jrc_pkg::AxisW-1:0] a;
	logic [jrc_pkg::AxisW-1:0] b;
	logic [jrc_pkg::ProdW-1:0] sq_a;
	logic [jrc_pkg::ProdW-1:0] sq_b;
	logic [jrc_pkg::SumW-1:0]  mag;
	jrc_pkg::jrc_work_t        work;
	logic                      valid_s1;
	jrc_pkg::jrc_work_t        work_s1;

	// raw / 4 exceeds 127 only when the top bit is set
	assign a    = in_data.x_raw[9] ? jrc_pkg::AxisMax : in_data.x_raw[8:2];
	assign b    = in_data.y_raw[9] ? jrc_pkg::AxisMax : in_data.y_raw[8:2];
	assign sq_a = a * a;
	assign sq_b = b * b;
	assign mag  = {1'b0, sq_a} + {1'b0, sq_b};

	always_comb begin
		work         = '0;
		work.x_raw   = in_data.x_raw;
		work.y_raw   = in_data.y_raw;
		work.a       = a;
		work.b       = b;
		work.lo      = jrc_pkg::FactorLo;
		work.hi      = jrc_pkg::FactorHi;
		work.outside = (mag > {1'b0, jrc_pkg::RadiusSq});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

// ===== src/jrc_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrc_iter
// one binary search step over the scale factor, split in two stages
// ----------------------------------------------------------------------------
module jrc_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  jrc_pkg::jrc_work_t in_work,
	output logic               out_valid,
	output jrc_pkg::jrc_work_t out_work
);

	logic [jrc_pkg::AxisW:0]   mid_sum;
	logic [jrc_pkg::AxisW-1:0] mid;
	logic [jrc_pkg::ProdW-1:0] prod_a;
	logic [jrc_pkg::ProdW-1:0] prod_b;
	jrc_pkg::jrc_work_t        work_mid;
	logic                      valid_s1;
	jrc_pkg::jrc_work_t        work_s1;
	logic [jrc_pkg::ProdW-1:0] sq_a;
	logic [jrc_pkg::ProdW-1:0] sq_b;
	logic [jrc_pkg::SumW-1:0]  mag;
	logic                      fits;
	jrc_pkg::jrc_work_t        work_next;
	logic                      valid_s2;
	jrc_pkg::jrc_work_t        work_s2;

	// stage 1: midpoint and scaled axes
	assign mid_sum = {1'b0, in_work.lo} + {1'b0, in_work.hi} + 8'd1;
	assign mid     = mid_sum[jrc_pkg::AxisW:1];
	assign prod_a  = in_work.a * mid;
	assign prod_b  = in_work.b * mid;

	always_comb begin
		work_mid     = in_work;
		work_mid.mid = mid;
		work_mid.sa  = prod_a[jrc_pkg::ProdW-1:jrc_pkg::FracW];
		work_mid.sb  = prod_b[jrc_pkg::ProdW-1:jrc_pkg::FracW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_mid;
		end
	end

	// stage 2: squared length of the scaled pair, narrow the range
	assign sq_a = work_s1.sa * work_s1.sa;
	assign sq_b = work_s1.sb * work_s1.sb;
	assign mag  = {1'b0, sq_a} + {1'b0, sq_b};
	assign fits = (mag <= {1'b0, jrc_pkg::RadiusSq});

	always_comb begin
		work_next = work_s1;
		if (fits) begin
			work_next.lo = work_s1.mid;
		end else begin
			work_next.hi = work_s1.mid - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s2 <= work_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_work  = work_s2;

endmodule

// ===== src/joystick_radial_clamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_radial_clamp
// pulls a joystick sample back onto a circle of radius 127 at quarter scale
// ----------------------------------------------------------------------------
//
// channel | handshake          | payload
// --------+--------------------+--------------------------------------
// in      | in_valid/in_ready  | in_data  (x_raw, y_raw)
// out     | out_valid/out_ready| out_data (x_out, y_out, was_scaled)
//
// the pipeline has one clamp stage, six search steps of two stages
// each (scale multiply, then square and compare), one output stage
// one item enters per cycle while not stalled; the whole pipeline advances together
// a stall holds every stage while the output register is full and not taken
// reset clears only the valid bits; the data registers are not reset
//
`include "joystick_radial_clamp_defines.svh"

module joystick_radial_clamp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  jrc_pkg::jrc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output jrc_pkg::jrc_out_t out_data
);

	// pipeline moves whenever the output slot is free or being drained
	logic en;

	// valid and work between stages: index 0 after the clamp stage,
	// index k after search step k
	logic               stage_valid [jrc_pkg::Iters+1];
	jrc_pkg::jrc_work_t stage_work  [jrc_pkg::Iters+1];

	// final scaling
	jrc_pkg::jrc_work_t        last_work;
	logic [jrc_pkg::ProdW-1:0] fin_a;
	logic [jrc_pkg::ProdW-1:0] fin_b;
	jrc_pkg::jrc_out_t         result;

	// output register
	logic              out_valid_q;
	jrc_pkg::jrc_out_t out_data_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// clamp each axis and test against the circle
	jrc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.out_valid (stage_valid[0]),
		.out_work  (stage_work[0])
	);

	// six halvings take the factor range 64..127 down to one value
	for (genvar gi = 0; gi < jrc_pkg::Iters; gi++) begin : g_iter
		jrc_iter u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (stage_valid[gi]),
			.in_work   (stage_work[gi]),
			.out_valid (stage_valid[gi+1]),
			.out_work  (stage_work[gi+1])
		);
	end

	assign last_work = stage_work[jrc_pkg::Iters];

	// scale by the chosen factor, back to full range by times 4
	assign fin_a = last_work.a * last_work.lo;
	assign fin_b = last_work.b * last_work.lo;

	always_comb begin
		if (last_work.outside) begin
			result.x_out      = {1'b0, fin_a[jrc_pkg::ProdW-1:jrc_pkg::FracW], 2'b00};
			result.y_out      = {1'b0, fin_b[jrc_pkg::ProdW-1:jrc_pkg::FracW], 2'b00};
			result.was_scaled = 1'b1;
		end else begin
			// inside or on the circle: raw samples pass through untouched
			result.x_out      = last_work.x_raw;
			result.y_out      = last_work.y_raw;
			result.was_scaled = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= stage_valid[jrc_pkg::Iters];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ready drops only behind a full, untaken output register
	`JRC_ASSERT(a_ready_stall, !in_ready |-> (out_valid && !out_ready), "ready low without stall")

	// a stalled pipeline keeps the item in front of the output stage
	`JRC_ASSERT_NEXT(a_stall_holds, !in_ready, $stable(stage_valid[jrc_pkg::Iters]), "pipeline moved during stall")

	// a scaled item has clear low bits and lies inside the circle
	`JRC_ASSERT(a_scaled_inside, (out_valid && out_data.was_scaled) |-> (out_data.x_out[1:0] == 2'b00 && out_data.y_out[1:0] == 2'b00 && ({6'd0, out_data.x_out[9:2]} * {6'd0, out_data.x_out[9:2]} + {6'd0, out_data.y_out[9:2]} * {6'd0, out_data.y_out[9:2]} <= 14'd16129)), "scaled item outside circle")

endmodule
